// File: design/irkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irkd_pkg: shared types and constants of the IR remote key decoder
// Event kinds, the stock key table and the match result struct.
// ----------------------------------------------------------------------------
package irkd_pkg;

    // Event kinds on the input channel
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_IDLE = 1'b1;

    localparam logic [7:0] THRESHOLD_RESET = 8'd32;

    localparam int unsigned STOCK_ROWS  = 8;
    localparam int unsigned STOCK_BYTES = 9;

    // Each row: nine code bytes, then the command character
    localparam logic [7:0] STOCK_KEYS [STOCK_ROWS][STOCK_BYTES + 1] = '{
        '{8'hBE, 8'hFF, 8'hEB, 8'hAA, 8'hAA, 8'hFE, 8'hFF, 8'hAB, 8'h02, 8'h50},
        '{8'hBE, 8'hFF, 8'hEB, 8'hAA, 8'hFE, 8'hFA, 8'hAB, 8'hAF, 8'h02, 8'h2B},
        '{8'hBE, 8'hFF, 8'hEB, 8'hAA, 8'hBA, 8'hBA, 8'hEF, 8'hEF, 8'h02, 8'h2D},
        '{8'hBE, 8'hFF, 8'hEB, 8'hAA, 8'hBE, 8'hFF, 8'hEB, 8'hAA, 8'h02, 8'h43},
        '{8'hBE, 8'hFF, 8'hEB, 8'hAA, 8'hAA, 8'hFA, 8'hFF, 8'hAF, 8'h02, 8'h53},
        '{8'hBE, 8'hFF, 8'hEB, 8'hAA, 8'hAA, 8'hFF, 8'hFF, 8'hAA, 8'h02, 8'h54},
        '{8'hBE, 8'hFF, 8'hEB, 8'hAA, 8'hEE, 8'hFE, 8'hBB, 8'hAB, 8'h02, 8'h74},
        '{8'hBE, 8'hFF, 8'hEB, 8'hAA, 8'hAE, 8'hFF, 8'hFB, 8'hAA, 8'h02, 8'h46}
    };

    typedef struct packed {
        logic       hit;
        logic [2:0] key_index;
        logic [7:0] key_code;
    } t_match;

    // Code byte of a table row; rows and bytes past the stock table are zero
    function automatic logic [7:0] key_byte(input int unsigned row, input int unsigned idx);
        logic [7:0] val;
        val = 8'h00;
        if (row < STOCK_ROWS && idx < STOCK_BYTES) begin
            val = STOCK_KEYS[row][idx];
        end
        return val;
    endfunction

    // Command character of a table row
    function automatic logic [7:0] key_char(input int unsigned row);
        logic [7:0] val;
        val = 8'h00;
        if (row < STOCK_ROWS) begin
            val = STOCK_KEYS[row][STOCK_BYTES];
        end
        return val;
    endfunction

endpackage

// File: design/irkd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irkd_if: valid/ready channels of the IR remote key decoder
// Line events in, decoded key results out.
// ----------------------------------------------------------------------------
interface irkd_event_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] interval;

    modport source (output valid, output kind, output interval, input ready);
    modport sink   (input valid, input kind, input interval, output ready);
endinterface

interface irkd_result_if;
    logic       valid;
    logic       ready;
    logic       matched;
    logic [2:0] key_index;
    logic [7:0] key_code;
    logic [6:0] bits_received;

    modport source (output valid, output matched, output key_index, output key_code,
                    output bits_received, input ready);
    modport sink   (input valid, input matched, input key_index, input key_code,
                    input bits_received, output ready);
endinterface

// File: design/irkd_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irkd_matcher: key table compare
// Compares a packed frame with every key row; the highest matching row wins.
// ----------------------------------------------------------------------------
module irkd_matcher #(
    parameter int FRAME_BYTES = 9,
    parameter int KEY_COUNT   = 8
) (
    input  logic [FRAME_BYTES*8-1:0] i_frame,
    output irkd_pkg::t_match         o_match
);

    localparam int FRAME_BITS = FRAME_BYTES * 8;

    logic [KEY_COUNT-1:0] w_row_hit;

    for (genvar gr = 0; gr < KEY_COUNT; gr++) begin : g_row
        logic [FRAME_BITS-1:0] w_row_code;
        for (genvar gb = 0; gb < FRAME_BYTES; gb++) begin : g_byte
            assign w_row_code[gb*8 +: 8] = irkd_pkg::key_byte(gr, gb);
        end
        assign w_row_hit[gr] = (i_frame == w_row_code);
    end

    // Later rows override earlier ones
    always_comb begin
        o_match = '0;
        for (int r = 0; r < KEY_COUNT; r++) begin
            if (w_row_hit[r]) begin
                o_match.hit       = 1'b1;
                o_match.key_index = 3'(r);
                o_match.key_code  = irkd_pkg::key_char(r);
            end
        end
    end

endmodule

// File: design/ir_remote_key_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_remote_key_decoder_unit: pulse-distance IR remote key decoder
// Collects frame bits from line events and looks the frame up in a key table.
// ----------------------------------------------------------------------------
// Usage:
//   i_evt carries line events: an edge with the interval since the previous
//   edge, or an idle timeout. The first edge opens a frame; each later edge
//   adds one bit (1 when interval < threshold). The frame closes on its last
//   bit or on idle, and one result goes out on o_res: match flag, row, command
//   character and bit count. Events that close nothing give no result.
//   i_cfg_we / i_cfg_wdata write the bit threshold; write only while idle.
//   A closing event goes from its transfer into the input register and
//   from there into the result register. Throughput: one event per cycle
//   while no result waits on o_res.ready, since the bit capture and the
//   parallel frame compare are combinational.
//   Reset: threshold 32, no frame open, output empty.
//   Stall: while a result waits on o_res.ready, the event held in the input
//   register waits too, and i_evt.ready drops once that register is full.
// ----------------------------------------------------------------------------
module ir_remote_key_decoder_unit #(
    parameter int FRAME_BYTES = 9,
    parameter int KEY_COUNT   = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    irkd_event_if.sink           i_evt,
    irkd_result_if.source        o_res
);

    localparam int FRAME_BITS = FRAME_BYTES * 8;
    localparam int CNT_W      = $clog2(FRAME_BITS + 1);
    localparam int IDX_W      = $clog2(FRAME_BITS);

    logic [7:0]            r_threshold;
    logic                  r_in_valid;
    logic                  r_kind;
    logic [7:0]            r_interval;
    logic [FRAME_BITS-1:0] r_frame;
    logic [CNT_W-1:0]      r_count;
    logic                  r_receiving;
    logic                  r_out_valid;
    irkd_pkg::t_match      r_match;
    logic [6:0]            r_bits;

    logic                  w_go;
    logic                  w_open;
    logic                  w_bit_edge;
    logic                  w_close;
    logic [FRAME_BITS-1:0] w_bit_sel;
    logic [FRAME_BITS-1:0] w_frame_upd;
    logic [CNT_W-1:0]      w_count_upd;
    irkd_pkg::t_match      w_match;

    // Work stage advances unless a finished result is still waiting
    assign w_go       = r_in_valid && (!r_out_valid || o_res.ready);
    assign w_open     = (r_kind == irkd_pkg::KIND_EDGE) && !r_receiving;
    assign w_bit_edge = (r_kind == irkd_pkg::KIND_EDGE) && r_receiving;
    assign w_bit_sel  = FRAME_BITS'(1) << r_count[IDX_W-1:0];

    always_comb begin
        w_frame_upd = r_frame;
        w_count_upd = r_count;
        if (w_bit_edge) begin
            if (r_interval < r_threshold) begin
                w_frame_upd = r_frame | w_bit_sel;
            end
            w_count_upd = r_count + CNT_W'(1);
        end
    end

    assign w_close = r_receiving &&
                     ((r_kind == irkd_pkg::KIND_IDLE) || (w_count_upd == CNT_W'(FRAME_BITS)));

    irkd_matcher #(
        .FRAME_BYTES (FRAME_BYTES),
        .KEY_COUNT   (KEY_COUNT)
    ) u_matcher (
        .i_frame (w_frame_upd),
        .o_match (w_match)
    );

    assign i_evt.ready = !r_in_valid || w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= irkd_pkg::THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_kind     <= i_evt.kind;
            r_interval <= i_evt.interval;
        end
    end

    // Frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= '0;
            r_count     <= '0;
            r_receiving <= 1'b0;
        end else if (w_go) begin
            if (w_open) begin
                r_frame     <= '0;
                r_count     <= '0;
                r_receiving <= 1'b1;
            end else begin
                r_frame <= w_frame_upd;
                r_count <= w_count_upd;
                if (w_close) begin
                    r_receiving <= 1'b0;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_close) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_close) begin
            r_match <= w_match;
            r_bits  <= 7'(w_count_upd);
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.matched       = r_match.hit;
    assign o_res.key_index     = r_match.key_index;
    assign o_res.key_code      = r_match.key_code;
    assign o_res.bits_received = r_bits;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FRAME_BITS))
        else $error("bit count past frame length");

    a_close_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_close) |=> (!r_receiving && r_out_valid))
        else $error("closed frame left open or result not loaded");

    a_open_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_open) |=> (r_receiving && r_count == '0 && r_frame == '0))
        else $error("new frame not cleared");

    a_no_result_unless_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && !r_receiving) |=> (!r_out_valid || $past(r_out_valid)))
        else $error("result produced with no frame open");

endmodule

// File: test/irkd_frame_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irkd_frame_check: key decode predictor and result checker
// Watches the event and result channels and the threshold write port. It keeps
// its own copy of the frame capture state, works out the key lookup of every
// frame that closes, and compares each result transfer with the oldest
// expected lookup. Mismatches are counted and handed up to the testbench.
// ----------------------------------------------------------------------------
module irkd_frame_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    irkd_event_if       evt,
    irkd_result_if      res,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int FRAME_BITS = irkd_pkg::STOCK_BYTES * 8;

    typedef struct packed {
        logic       matched;
        logic [2:0] key_index;
        logic [7:0] key_code;
        logic [6:0] bits_received;
    } t_key_lookup;

    logic [7:0]            threshold;
    logic [FRAME_BITS-1:0] frame;
    int                    frame_len;
    logic                  frame_open;
    t_key_lookup           lookups_due[$];
    int                    fails = 0;

    // Highest matching row wins; every byte must match
    function automatic t_key_lookup lookup_frame();
        t_key_lookup r;
        logic        eq;
        r = '0;
        for (int row = 0; row < irkd_pkg::STOCK_ROWS; row++) begin
            eq = 1'b1;
            for (int b = 0; b < irkd_pkg::STOCK_BYTES; b++) begin
                if (irkd_pkg::STOCK_KEYS[row][b] != frame[8*b +: 8]) begin
                    eq = 1'b0;
                end
            end
            if (eq) begin
                r.matched   = 1'b1;
                r.key_index = row[2:0];
                r.key_code  = irkd_pkg::STOCK_KEYS[row][irkd_pkg::STOCK_BYTES];
            end
        end
        r.bits_received = frame_len[6:0];
        return r;
    endfunction

    task automatic close_frame();
        lookups_due.push_back(lookup_frame());
        frame_open = 1'b0;
    endtask

    task automatic decode_event(input logic kind, input logic [7:0] interval);
        if (kind == irkd_pkg::KIND_IDLE) begin
            if (frame_open) begin
                close_frame();
            end
        end else if (!frame_open) begin
            // opening edge only starts timing
            frame_open = 1'b1;
            frame      = '0;
            frame_len  = 0;
        end else begin
            if (frame_len < FRAME_BITS) begin
                if (interval < threshold) begin
                    frame[frame_len] = 1'b1;
                end
                frame_len++;
            end
            if (frame_len >= FRAME_BITS) begin
                close_frame();
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_key_lookup got;
        t_key_lookup want;
        if (!i_rst_n) begin
            threshold  = irkd_pkg::THRESHOLD_RESET;
            frame      = '0;
            frame_len  = 0;
            frame_open = 1'b0;
            lookups_due.delete();
        end else begin
            if (i_cfg_we) begin
                threshold = i_cfg_wdata;
            end
            if (evt.valid && evt.ready) begin
                decode_event(evt.kind, evt.interval);
            end
            if (res.valid && res.ready) begin
                got = '{res.matched, res.key_index, res.key_code, res.bits_received};
                if (lookups_due.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t: unexpected result matched=%0d row=%0d code=%02h bits=%0d",
                                 $time, got.matched, got.key_index, got.key_code,
                                 got.bits_received);
                    end
                end else begin
                    want = lookups_due.pop_front();
                    if (got.matched !== want.matched || got.key_index !== want.key_index ||
                        got.key_code !== want.key_code ||
                        got.bits_received !== want.bits_received) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: result mismatch exp matched=%0d row=%0d code=%02h bits=%0d",
                                     $time, want.matched, want.key_index, want.key_code,
                                     want.bits_received);
                            $display("%0t:                 got matched=%0d row=%0d code=%02h bits=%0d",
                                     $time, got.matched, got.key_index, got.key_code,
                                     got.bits_received);
                        end
                    end
                end
            end
        end
        o_pending    <= lookups_due.size();
        o_fail_count <= fails;
    end

endmodule

// File: test/tb_ir_remote_key_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ir_remote_key_decoder_unit: testbench of the IR remote key decoder
// Sends directed and random line event sequences, mostly key frames (whole,
// cut short or with one bit flipped) with random timing, under several bit thresholds, with bursty input and a
// stalling result side. The frame checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ir_remote_key_decoder_unit;

    localparam int FRAME_BITS = irkd_pkg::STOCK_BYTES * 8;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    int         fail_count;
    int         pending;

    irkd_event_if  evt_ch ();
    irkd_result_if res_ch ();

    logic [7:0]  thr_now = irkd_pkg::THRESHOLD_RESET;
    int          burst_left = 0;
    int          events_sent = 0;
    logic [15:0] stall_pat = 16'hFFFF;
    logic [5:0]  stall_age = '0;

    ir_remote_key_decoder_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_evt       (evt_ch),
        .o_res       (res_ch)
    );

    irkd_frame_check frame_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .evt          (evt_ch),
        .res          (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side: rotate a stall pattern, pick a new one each time stall_age wraps
    always @(posedge clk) begin
        if (stall_age == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pat = 16'hFFFF;
                1: stall_pat = 16'($urandom() | $urandom()) | 16'h0001;
                2: stall_pat = 16'($urandom()) | 16'h0001;
                default: stall_pat = 16'($urandom() & $urandom()) | 16'h0001;
            endcase
        end
        res_ch.ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
        stall_age = stall_age + 1'b1;
    end

    initial begin
        #4_000_000;
        $display("tb_ir_remote_key_decoder_unit failed");
        $finish;
    end

    // Hold the event until it transfers; open a random gap between bursts
    task automatic put_event(input logic kind, input logic [7:0] interval);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                evt_ch.valid    <= 1'b0;
                evt_ch.kind     <= 1'($urandom_range(0, 1));
                evt_ch.interval <= 8'($urandom_range(0, 255));
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        evt_ch.valid    <= 1'b1;
        evt_ch.kind     <= kind;
        evt_ch.interval <= interval;
        @(posedge clk);
        while (!evt_ch.ready) @(posedge clk);
        events_sent++;
    endtask

    // Wait until every expected result has come and the pipeline is empty
    task automatic drain();
        evt_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        thr_now = value;
    endtask

    function automatic logic [7:0] bit_interval(input logic one);
        logic [7:0] val;
        if (one && thr_now != 0) begin
            val = 8'($urandom_range(0, thr_now - 1));
        end else if (!one) begin
            val = 8'($urandom_range(thr_now, 255));
        end else begin
            val = 8'($urandom_range(0, 255));
        end
        return val;
    endfunction

    function automatic logic [FRAME_BITS-1:0] key_frame(input int row);
        logic [FRAME_BITS-1:0] code;
        for (int b = 0; b < irkd_pkg::STOCK_BYTES; b++) begin
            code[8*b +: 8] = irkd_pkg::STOCK_KEYS[row][b];
        end
        return code;
    endfunction

    // Opening edge, then one edge per bit; close on idle when short or when extra_idle is set
    task automatic send_frame(input logic [FRAME_BITS-1:0] code, input int nbits,
                              input logic extra_idle);
        put_event(irkd_pkg::KIND_EDGE, 8'($urandom_range(0, 255)));
        for (int i = 0; i < nbits; i++) begin
            put_event(irkd_pkg::KIND_EDGE, bit_interval(code[i]));
        end
        if (nbits < FRAME_BITS || extra_idle) begin
            put_event(irkd_pkg::KIND_IDLE, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_random_frame();
        int                    sel;
        int                    nbits;
        logic [FRAME_BITS-1:0] code;
        logic [95:0]           draw;
        sel   = $urandom_range(0, 9);
        code  = key_frame($urandom_range(0, irkd_pkg::STOCK_ROWS - 1));
        nbits = FRAME_BITS;
        draw  = {$urandom(), $urandom(), $urandom()};
        case (sel)
            3: nbits = $urandom_range(66, FRAME_BITS - 1);
            4: code[$urandom_range(0, FRAME_BITS - 1)] ^= 1'b1;
            5: nbits = $urandom_range(0, 65);
            6, 7: begin
                code  = draw[FRAME_BITS-1:0];
                nbits = $urandom_range(0, FRAME_BITS);
            end
            9: code = draw[FRAME_BITS-1:0];
            default: ;
        endcase
        if (sel == 8) begin
            repeat ($urandom_range(1, 8)) begin
                put_event(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end else begin
            send_frame(code, nbits, sel == 9);
        end
    endtask

    initial begin
        logic [7:0] phase_thr [6];
        int         phase_start;
        int         frames;
        int         waited;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        evt_ch.valid    <= 1'b0;
        evt_ch.kind     <= irkd_pkg::KIND_EDGE;
        evt_ch.interval <= '0;
        phase_thr = '{irkd_pkg::THRESHOLD_RESET, 8'd1, 8'd255, 8'd0,
                      8'($urandom_range(2, 254)), 8'($urandom_range(2, 254))};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        write_threshold(irkd_pkg::THRESHOLD_RESET);

        // Directed: idle with nothing open, empty frame, threshold edges
        put_event(irkd_pkg::KIND_IDLE, 8'd0);
        put_event(irkd_pkg::KIND_EDGE, 8'd0);
        put_event(irkd_pkg::KIND_IDLE, 8'd255);
        put_event(irkd_pkg::KIND_IDLE, 8'd0);
        put_event(irkd_pkg::KIND_EDGE, 8'd255);
        put_event(irkd_pkg::KIND_EDGE, 8'd0);
        put_event(irkd_pkg::KIND_EDGE, 8'd255);
        put_event(irkd_pkg::KIND_EDGE, irkd_pkg::THRESHOLD_RESET - 8'd1);
        put_event(irkd_pkg::KIND_EDGE, irkd_pkg::THRESHOLD_RESET);
        put_event(irkd_pkg::KIND_IDLE, 8'd0);
        put_event(irkd_pkg::KIND_EDGE, 8'd128);
        put_event(irkd_pkg::KIND_EDGE, 8'd128);
        put_event(irkd_pkg::KIND_IDLE, 8'd128);

        for (int p = 0; p < 6; p++) begin
            write_threshold(phase_thr[p]);
            phase_start = events_sent;
            frames = 0;
            while (events_sent - phase_start < 270 || frames < 3) begin
                send_random_frame();
                frames++;
            end
        end

        evt_ch.valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge clk);
            waited++;
        end while (pending != 0 && waited < 5000);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb_ir_remote_key_decoder_unit passed");
        end else begin
            $display("tb_ir_remote_key_decoder_unit failed");
        end
        $finish;
    end

endmodule
